// File: hdl/lru_value_list_unit_assert.svh
// ----------------------------------------------------------------------------
// lru value list assertion macros
// shared assertion forms for the lru value list checker
// ----------------------------------------------------------------------------
`ifndef LRU_VALUE_LIST_UNIT_ASSERT_SVH
`define LRU_VALUE_LIST_UNIT_ASSERT_SVH

// property sampled on clk_i, disabled during reset
`define LVL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lvl checker: property failed");

// condition in a cycle implies hold in the next
`define LVL_ASSERT_NEXT(lbl, cond, hold) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (hold)) \
    else $error("lvl checker: next-cycle property failed");

`endif

// File: hdl/lvl_pkg.sv
// ----------------------------------------------------------------------------
// lru value list package
// shared constants, codes and types of the lru value list unit
// ----------------------------------------------------------------------------
package lvl_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CAP_W           = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam logic REP_INSERT = 1'b0;
  localparam logic REP_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_COMPACT,
    OP_SHIFT,
    OP_FILL
  } lvl_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPACT,
    ST_MARK_INS,
    ST_CLEAR
  } lvl_state_e;

  typedef struct packed {
    lvl_op_e op;
    logic    key_marker;
  } lvl_cell_cmd_t;

  typedef struct packed {
    logic hit;
    logic head_marker;
    logic tail_marker;
  } lvl_status_t;

endpackage

// File: hdl/lvl_cell.sv
// ----------------------------------------------------------------------------
// lru value list cell
// one list slot: holds a value, compares it against the key and takes the
// value of either neighbor, or all ones, as the row command says
// ----------------------------------------------------------------------------
module lvl_cell import lvl_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lvl_op_e                op_i,
  input  logic [VALUE_WIDTH-1:0] key_i,
  input  logic [VALUE_WIDTH-1:0] prev_i,
  input  logic [VALUE_WIDTH-1:0] next_i,
  input  logic                   in_use_i,
  input  logic                   chain_i,
  output logic                   chain_o,
  output logic [VALUE_WIDTH-1:0] value_o
);

  logic [VALUE_WIDTH-1:0] value_q, value_d;

  assign chain_o = chain_i | (in_use_i & (value_q == key_i));
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    case (op_i)
      OP_FILL: begin
        value_d = {VALUE_WIDTH{1'b1}};
      end
      OP_INSERT: begin
        if (in_use_i && !chain_i) begin
          value_d = prev_i;
        end
      end
      OP_COMPACT: begin
        if (chain_o) begin
          value_d = next_i;
        end
      end
      OP_SHIFT: begin
        value_d = next_i;
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= {VALUE_WIDTH{1'b1}};
    end else begin
      value_q <= value_d;
    end
  end

endmodule

// File: hdl/lvl_ctrl.sv
// ----------------------------------------------------------------------------
// lru value list control
// sequences inserts, compaction and clear streaming over the cell row and
// holds the output word register
// ----------------------------------------------------------------------------
module lvl_ctrl import lvl_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    cmd_i,
  input  logic                                    is_marker_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] cap_m1_i,
  input  lvl_status_t                             status_i,
  input  logic [VALUE_WIDTH-1:0]                  head_i,
  input  logic [VALUE_WIDTH-1:0]                  tail_i,
  output lvl_cell_cmd_t                           cell_cmd_o,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic                                    report_kind_o,
  output logic                                    was_present_o,
  output logic                                    entry_valid_o,
  output logic [VALUE_WIDTH-1:0]                  entry_value_o,
  output logic                                    last_o
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lvl_state_e             state_q, state_d;
  logic [IDX_W-1:0]       cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic                   kind_q, kind_d;
  logic                   present_q, present_d;
  logic                   evalid_q, evalid_d;
  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic                   last_q, last_d;
  logic                   load;
  logic                   out_free;
  logic                   accept;
  logic                   cnt_last;
  logic                   drop;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign cnt_last   = (cnt_q == cap_m1_i);
  assign drop       = !status_i.hit && !status_i.tail_marker;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_CLEAR) begin
            state_d = ST_CLEAR;
            cnt_d   = '0;
          end else if (is_marker_i) begin
            state_d = ST_COMPACT;
            cnt_d   = '0;
          end
        end
      end
      ST_COMPACT: begin
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_last) begin
          state_d = ST_MARK_INS;
        end
      end
      ST_MARK_INS: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (out_free) begin
          cnt_d = cnt_q + IDX_W'(1);
          if (cnt_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // row command and output word
  always_comb begin
    cell_cmd_o.op         = OP_HOLD;
    cell_cmd_o.key_marker = 1'b1;
    load                  = 1'b0;
    kind_d                = REP_INSERT;
    present_d             = status_i.hit;
    evalid_d              = drop;
    value_d               = drop ? tail_i : '0;
    last_d                = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (accept && (cmd_i == CMD_INSERT) && !is_marker_i) begin
          cell_cmd_o.op         = OP_INSERT;
          cell_cmd_o.key_marker = 1'b0;
          load                  = 1'b1;
        end
      end
      ST_COMPACT: begin
        cell_cmd_o.op = OP_COMPACT;
      end
      ST_MARK_INS: begin
        if (out_free) begin
          cell_cmd_o.op = OP_INSERT;
          load          = 1'b1;
        end
      end
      ST_CLEAR: begin
        kind_d    = REP_CLEAR;
        present_d = 1'b0;
        evalid_d  = !status_i.head_marker;
        value_d   = head_i;
        last_d    = cnt_last;
        if (out_free) begin
          cell_cmd_o.op = OP_SHIFT;
          load          = 1'b1;
        end
      end
      default: begin
        cell_cmd_o.op = OP_HOLD;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q    <= kind_d;
      present_q <= present_d;
      evalid_q  <= evalid_d;
      value_q   <= value_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign report_kind_o = kind_q;
  assign was_present_o = present_q;
  assign entry_valid_o = evalid_q;
  assign entry_value_o = value_q;
  assign last_o        = last_q;

endmodule

// File: hdl/lru_value_list_unit.sv
// ----------------------------------------------------------------------------
// lru value list unit
// most-recently-used list of values held in a row of compare-and-shift cells
// ----------------------------------------------------------------------------
//  channel  | signals                                  | moves
//  ---------+------------------------------------------+---------------------
//  in       | in_valid_i, in_ready_o, cmd_i,           | one command word
//           | insert_value_i                           |
//  out      | out_valid_o, out_ready_i, report_kind_o, | one report word
//           | was_present_o, entry_valid_o,            |
//           | entry_value_o, last_o                    |
//  cfg      | cfg_we_i, cfg_wdata_i                    | capacity write
//
//  insert of any value but all ones: one word every cycle while out_ready_i is high
//  insert of all ones: a compaction pass down the row, then the marker insert
//  clear: one slot word per slot in use out of cell 0, one per cycle while out_ready_i is high
//  reset: every slot all ones, capacity = DEPTH (low 5 bits)
//  a waiting report word holds off the next command word until it is taken
// ----------------------------------------------------------------------------
module lru_value_list_unit import lvl_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   cmd_i,
  input  logic [VALUE_WIDTH-1:0] insert_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   report_kind_o,
  output logic                   was_present_o,
  output logic                   entry_valid_o,
  output logic [VALUE_WIDTH-1:0] entry_value_o,
  output logic                   last_o,
  input  logic                   cfg_we_i,
  input  logic [CAP_W-1:0]       cfg_wdata_i
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CAP_W-1:0]       cap_q;
  logic [CNT_W-1:0]       cap_eff;
  logic [CNT_W-1:0]       cap_m1;
  lvl_cell_cmd_t          cell_cmd;
  lvl_op_e                cell_op;
  lvl_status_t            status;
  logic [VALUE_WIDTH-1:0] key;
  logic [VALUE_WIDTH-1:0] slot_val [DEPTH];
  logic                   chain [DEPTH+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(DEPTH);
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap_q) > 32'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_q);
    end
  end

  assign cap_m1  = cap_eff - CNT_W'(1);
  assign cell_op = cfg_we_i ? OP_FILL : cell_cmd.op;
  assign key     = cell_cmd.key_marker ? {VALUE_WIDTH{1'b1}} : insert_value_i;

  assign chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] POS = CNT_W'(i);
    logic [VALUE_WIDTH-1:0] prev_val;
    logic [VALUE_WIDTH-1:0] next_val;

    if (i == 0) begin : g_head
      assign prev_val = key;
    end else begin : g_body
      assign prev_val = slot_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_val = {VALUE_WIDTH{1'b1}};
    end else begin : g_mid
      assign next_val = slot_val[i+1];
    end

    lvl_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (cell_op),
      .key_i   (key),
      .prev_i  (prev_val),
      .next_i  (next_val),
      .in_use_i(POS < cap_eff),
      .chain_i (chain[i]),
      .chain_o (chain[i+1]),
      .value_o (slot_val[i])
    );
  end

  assign status.hit         = chain[DEPTH];
  assign status.head_marker = (slot_val[0] == {VALUE_WIDTH{1'b1}});
  assign status.tail_marker = (slot_val[cap_m1[IDX_W-1:0]] == {VALUE_WIDTH{1'b1}});

  lvl_ctrl #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .is_marker_i  (insert_value_i == {VALUE_WIDTH{1'b1}}),
    .cap_m1_i     (cap_m1[IDX_W-1:0]),
    .status_i     (status),
    .head_i       (slot_val[0]),
    .tail_i       (slot_val[cap_m1[IDX_W-1:0]]),
    .cell_cmd_o   (cell_cmd),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .report_kind_o(report_kind_o),
    .was_present_o(was_present_o),
    .entry_valid_o(entry_valid_o),
    .entry_value_o(entry_value_o),
    .last_o       (last_o)
  );

endmodule

// File: hdl/lvl_checker.sv
// ----------------------------------------------------------------------------
// lru value list checker
// port-level properties of the lru value list unit, bound to the top level
// ----------------------------------------------------------------------------
`include "lru_value_list_unit_assert.svh"

module lvl_checker import lvl_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   cmd_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic                   report_kind_o,
  input logic                   was_present_o,
  input logic                   entry_valid_o,
  input logic [VALUE_WIDTH-1:0] entry_value_o,
  input logic                   last_o
);

  // stalled output word holds
  `LVL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(entry_value_o) && $stable(last_o) && $stable(report_kind_o))

  `LVL_ASSERT(a_insert_last, out_valid_o && (report_kind_o == REP_INSERT) |-> last_o)

  `LVL_ASSERT(a_clear_no_hit, out_valid_o && (report_kind_o == REP_CLEAR) |-> !was_present_o)

  `LVL_ASSERT(a_valid_not_marker,
    out_valid_o && entry_valid_o |-> entry_value_o != {VALUE_WIDTH{1'b1}})

  // a clear keeps the unit busy in the cycle after it is accepted
  `LVL_ASSERT_NEXT(a_clear_busy,
    in_valid_i && in_ready_o && (cmd_i == CMD_CLEAR), !in_ready_o)

endmodule

bind lru_value_list_unit lvl_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_lvl_checker (.*);

// File: tb/sv/lru_value_list_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru value list unit testbench
// drives command words through the valid/ready input, predicts every report
// word from a behavioral copy of the list and compares them in order; runs a
// directed table first, then random phases over several capacity settings
// ----------------------------------------------------------------------------
module lru_value_list_unit_tb;
  import lvl_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int VW = VALUE_WIDTH_DEF;
  localparam logic [VW-1:0] MARKER = '1;
  localparam int SETTLE_CYCLES = DEPTH + 4;

  typedef struct packed {
    logic          kind;
    logic          present;
    logic          valid;
    logic [VW-1:0] value;
    logic          last;
  } report_t;

  typedef struct {
    logic [CAP_W-1:0] cap;
    logic             cmd;
    logic [VW-1:0]    value;
    bit               typed;
    report_t          exp;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             cmd_i;
  logic [VW-1:0]    insert_value_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             report_kind_o;
  logic             was_present_o;
  logic             entry_valid_o;
  logic [VW-1:0]    entry_value_o;
  logic             last_o;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;

  logic [VW-1:0]    lru_slots[DEPTH];
  logic [CAP_W-1:0] capacity_reg;
  report_t          pending_reports[$];
  int               fail_count;
  bit               no_idle;

  localparam int NUM_ROWS = 20;
  stim_row_t directed_rows[NUM_ROWS] = '{
    '{5'd16, CMD_INSERT, 32'h0000_0000, 1'b1, '{REP_INSERT, 1'b0, 1'b0, 32'h0, 1'b1}},
    '{5'd16, CMD_INSERT, 32'hFFFF_FFFF, 1'b1, '{REP_INSERT, 1'b1, 1'b0, 32'h0, 1'b1}},
    '{5'd16, CMD_INSERT, 32'h0000_0000, 1'b0, '0},
    '{5'd16, CMD_INSERT, 32'h0000_0001, 1'b0, '0},
    '{5'd16, CMD_INSERT, 32'h8000_0000, 1'b0, '0},
    '{5'd16, CMD_INSERT, 32'h7FFF_FFFF, 1'b0, '0},
    '{5'd16, CMD_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
    '{5'd16, CMD_INSERT, 32'h5555_5555, 1'b0, '0},
    '{5'd16, CMD_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
    '{5'd16, CMD_CLEAR,  32'h0000_0000, 1'b0, '0},
    '{5'd16, CMD_INSERT, 32'hFFFF_FFFF, 1'b1, '{REP_INSERT, 1'b1, 1'b0, 32'h0, 1'b1}},
    '{5'd16, CMD_INSERT, 32'h1234_5678, 1'b1, '{REP_INSERT, 1'b0, 1'b0, 32'h0, 1'b1}},
    '{5'd1,  CMD_INSERT, 32'hDEAD_BEEF, 1'b1, '{REP_INSERT, 1'b0, 1'b0, 32'h0, 1'b1}},
    '{5'd1,  CMD_INSERT, 32'h0000_0002, 1'b1,
      '{REP_INSERT, 1'b0, 1'b1, 32'hDEAD_BEEF, 1'b1}},
    '{5'd1,  CMD_INSERT, 32'h0000_0002, 1'b0, '0},
    '{5'd1,  CMD_CLEAR,  32'hFFFF_FFFF, 1'b0, '0},
    '{5'd0,  CMD_INSERT, 32'h0000_0005, 1'b0, '0},
    '{5'd0,  CMD_INSERT, 32'h0000_0006, 1'b0, '0},
    '{5'd31, CMD_INSERT, 32'h0000_0007, 1'b0, '0},
    '{5'd31, CMD_CLEAR,  32'h0000_0000, 1'b0, '0}
  };

  localparam int NUM_PHASES = 12;
  logic [CAP_W-1:0] phase_caps[NUM_PHASES] = '{
    5'd2, 5'd16, 5'd3, 5'd31, 5'd4, 5'd17, 5'd8, 5'd1, 5'd5, 5'd0, 5'd15, 5'd16
  };

  lru_value_list_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .insert_value_i (insert_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .report_kind_o  (report_kind_o),
    .was_present_o  (was_present_o),
    .entry_valid_o  (entry_valid_o),
    .entry_value_o  (entry_value_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int slots_in_use();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > DEPTH) return DEPTH;
    return int'(capacity_reg);
  endfunction

  function automatic void invalidate_slots();
    for (int i = 0; i < DEPTH; i++) lru_slots[i] = MARKER;
  endfunction

  // update the list copy and queue the report words of one command word
  function automatic void predict_reports(input logic cmd, input logic [VW-1:0] value);
    int            used;
    int            k;
    logic [VW-1:0] next_slots[DEPTH];
    bit            hit;
    bit            fell;
    logic [VW-1:0] fell_value;
    report_t       rep;
    used = slots_in_use();
    if (cmd == CMD_CLEAR) begin
      for (int i = 0; i < used; i++) begin
        rep.kind    = REP_CLEAR;
        rep.present = 1'b0;
        rep.valid   = (lru_slots[i] != MARKER);
        rep.value   = lru_slots[i];
        rep.last    = (i == used - 1);
        pending_reports.push_back(rep);
      end
      invalidate_slots();
    end else begin
      hit = 0;
      fell = 0;
      fell_value = '0;
      k = 1;
      next_slots[0] = value;
      for (int i = 0; i < used; i++) begin
        if (lru_slots[i] == value) begin
          hit = 1;
        end else if (k < used) begin
          next_slots[k] = lru_slots[i];
          k++;
        end else if (lru_slots[i] != MARKER) begin
          fell = 1;
          fell_value = lru_slots[i];
        end
      end
      for (; k < used; k++) next_slots[k] = MARKER;
      for (int i = 0; i < used; i++) lru_slots[i] = next_slots[i];
      rep.kind    = REP_INSERT;
      rep.present = hit;
      rep.valid   = fell;
      rep.value   = fell ? fell_value : '0;
      rep.last    = 1'b1;
      pending_reports.push_back(rep);
    end
  endfunction

  function automatic void check_field(input string name, input logic [VW-1:0] exp,
                                      input logic [VW-1:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, actual %0h", name, exp, act);
      fail_count++;
    end
  endfunction

  always @(negedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(0, 99) >= 9);
  end

  always @(posedge clk_i) begin
    report_t exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $error("report word with none expected");
        fail_count++;
      end else begin
        exp = pending_reports.pop_front();
        check_field("report_kind", VW'(exp.kind), VW'(report_kind_o));
        check_field("was_present", VW'(exp.present), VW'(was_present_o));
        check_field("entry_valid", VW'(exp.valid), VW'(entry_valid_o));
        check_field("entry_value", exp.value, entry_value_o);
        check_field("last", VW'(exp.last), VW'(last_o));
      end
    end
  end

  task automatic send_word(input logic cmd, input logic [VW-1:0] value);
    @(negedge clk_i);
    if (!no_idle && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    insert_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    predict_reports(cmd, value);
  endtask

  task automatic drain_reports();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    capacity_reg = cap;
    invalidate_slots();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    #3_000_000;
    $display("lru_value_list_unit_tb NOT OK");
    $finish;
  end

  initial begin
    logic [VW-1:0] pool[DEPTH + 4];
    int            pool_size;
    int            pick;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    cmd_i          = CMD_INSERT;
    insert_value_i = '0;
    out_ready_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    fail_count     = 0;
    no_idle        = 0;
    capacity_reg   = CAP_W'(DEPTH);
    invalidate_slots();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].cap != capacity_reg) write_capacity(directed_rows[r].cap);
      send_word(directed_rows[r].cmd, directed_rows[r].value);
      if (directed_rows[r].typed)
        pending_reports[pending_reports.size() - 1] = directed_rows[r].exp;
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(phase_caps[p]);
      no_idle = (p == 2);
      // a pool a bit larger than the list gives hits, misses and evictions
      pool_size = slots_in_use() + 2;
      for (int i = 0; i < pool_size; i++) pool[i] = $urandom();
      for (int n = 0; n < 12; n++) begin
        if (p == 5 && n == 7) drain_reports();
        pick = $urandom_range(0, 99);
        if (pick < 8)
          send_word(CMD_CLEAR, $urandom());
        else if (pick < 13)
          send_word(CMD_INSERT, MARKER);
        else if (pick < 22)
          send_word(CMD_INSERT, $urandom());
        else
          send_word(CMD_INSERT, pool[$urandom_range(0, pool_size - 1)]);
      end
    end

    no_idle = 0;
    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("lru_value_list_unit_tb OK");
    end else begin
      $display("lru_value_list_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
